FILE: hdl/aip_pkg.sv
package aip_pkg;

  localparam int CH_W      = 8;
  localparam int VALUE_W   = 32;
  localparam int OFF_W     = 16;
  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int MAX_CHARS = 65535;

  localparam logic [OFF_W-1:0] OFF_CAP =
    OFF_W'((MAX_CHARS < 65535) ? MAX_CHARS : 65535);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_RST  = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_AUTO = RADIX_W'(0);
  localparam logic [RADIX_W-1:0] BASE_DEC   = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] BASE_HEX   = RADIX_W'(16);

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = '1;
  localparam logic [CH_W-1:0]    ALPHA_OFS  = CH_W'(10);

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic               first;
    logic               is_space;
    logic               is_sign;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } cls_t;

  typedef enum logic [4:0] {
    PH_DONE   = 5'b00001,
    PH_SPACE  = 5'b00010,
    PH_SIGNED = 5'b00100,
    PH_ZERO   = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA + ALPHA_OFS);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA + ALPHA_OFS);
    end
    return d;
  endfunction

endpackage

FILE: hdl/aip_ifs.sv
interface aip_in_if;
  logic                     valid;
  logic                     ready;
  logic [aip_pkg::CH_W-1:0] ch;
  logic                     first;
  modport source(output valid, ch, first, input ready);
  modport sink(input valid, ch, first, output ready);
endinterface

interface aip_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [aip_pkg::VALUE_W-1:0] value;
  logic [aip_pkg::OFF_W-1:0]          end_offset;
  modport source(output valid, value, end_offset, input ready);
  modport sink(input valid, value, end_offset, output ready);
endinterface

interface aip_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [aip_pkg::RADIX_W-1:0] radix;
  modport source(output valid, radix, input ready);
  modport sink(input valid, radix, output ready);
endinterface

FILE: hdl/aip_front.sv
module aip_front (
  input  logic          clk,
  input  logic          rst_n,
  aip_in_if.sink        in_chan,
  output logic          cls_vld,
  input  logic          cls_rdy,
  output aip_pkg::cls_t cls
);

  logic          vld_r;
  aip_pkg::cls_t cls_r;
  aip_pkg::cls_t cls_nxt;
  logic          accept;

  assign in_chan.ready = !vld_r || cls_rdy;
  assign accept        = in_chan.valid && in_chan.ready;
  assign cls_vld       = vld_r;
  assign cls           = cls_r;

  always_comb begin
    cls_nxt.first    = in_chan.first;
    cls_nxt.is_space = (in_chan.ch == aip_pkg::CH_SPACE) || (in_chan.ch == aip_pkg::CH_TAB) ||
                       (in_chan.ch == aip_pkg::CH_LF);
    cls_nxt.is_sign  = (in_chan.ch == aip_pkg::CH_PLUS) || (in_chan.ch == aip_pkg::CH_MINUS);
    cls_nxt.is_minus = (in_chan.ch == aip_pkg::CH_MINUS);
    cls_nxt.is_zero  = (in_chan.ch == aip_pkg::CH_ZERO);
    cls_nxt.is_x     = (in_chan.ch == aip_pkg::CH_LX) || (in_chan.ch == aip_pkg::CH_UX);
    cls_nxt.digit    = aip_pkg::digit_of(in_chan.ch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

FILE: hdl/aip_queue.sv
module aip_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_vld,
  output logic          push_rdy,
  input  aip_pkg::cls_t push_data,
  output logic          pop_vld,
  input  logic          pop,
  output aip_pkg::cls_t pop_data
);

  aip_pkg::cls_t               mem_r [aip_pkg::QDEPTH];
  logic [aip_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [aip_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [aip_pkg::QCNT_W-1:0]  count_r;
  logic [aip_pkg::QCNT_W-1:0]  count_nxt;
  logic                        push;
  logic                        pop_ok;

  assign push_rdy = (count_r != aip_pkg::QCNT_W'(aip_pkg::QDEPTH));
  assign pop_vld  = (count_r != '0);
  assign push     = push_vld && push_rdy;
  assign pop_ok   = pop && pop_vld;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/aip_back.sv
module aip_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_vld,
  input  aip_pkg::cls_t               head,
  output logic                        pop,
  input  logic [aip_pkg::RADIX_W-1:0] radix,
  aip_out_if.source                   out_chan
);

  aip_pkg::phase_t              ph_r, ph_nxt, ph;
  logic                         neg_r, neg_nxt, neg;
  logic [aip_pkg::VALUE_W-1:0]  acc_r, acc_nxt, acc;
  logic [aip_pkg::RADIX_W-1:0]  base_r, base_nxt, base;
  logic [aip_pkg::OFF_W-1:0]    cons_r, cons_nxt, cons, cons_inc;
  logic [aip_pkg::RADIX_W-1:0]  auto_base;
  logic [aip_pkg::RADIX_W-1:0]  zero_base;
  logic [aip_pkg::RADIX_W-1:0]  tb;
  logic                         zero_ok;
  logic                         take;
  logic                         emit;
  logic                         out_free;

  logic                         out_vld_r;
  logic [aip_pkg::VALUE_W-1:0]  value_r;
  logic [aip_pkg::OFF_W-1:0]    off_r;

  assign ph   = head.first ? aip_pkg::PH_SPACE : ph_r;
  assign neg  = head.first ? 1'b0 : neg_r;
  assign acc  = head.first ? '0 : acc_r;
  assign base = head.first ? '0 : base_r;
  assign cons = head.first ? '0 : cons_r;

  assign cons_inc  = (cons < aip_pkg::OFF_CAP) ? cons + 1'b1 : cons;
  assign auto_base = (radix == aip_pkg::RADIX_AUTO) ? aip_pkg::BASE_DEC : radix;
  assign zero_base = (radix == aip_pkg::RADIX_AUTO) ? aip_pkg::BASE_DEC : aip_pkg::BASE_HEX;
  assign zero_ok   = ((radix == aip_pkg::RADIX_AUTO) || (radix == aip_pkg::BASE_HEX)) &&
                     head.is_zero;

  always_comb begin
    ph_nxt   = ph;
    neg_nxt  = neg;
    acc_nxt  = acc;
    base_nxt = base;
    cons_nxt = cons;
    take     = 1'b0;
    tb       = base;
    emit     = 1'b0;
    unique case (ph)
      aip_pkg::PH_SPACE, aip_pkg::PH_SIGNED: begin
        if (ph == aip_pkg::PH_SPACE && head.is_space) begin
          cons_nxt = cons_inc;
        end else if (ph == aip_pkg::PH_SPACE && head.is_sign) begin
          neg_nxt  = head.is_minus;
          cons_nxt = cons_inc;
          ph_nxt   = aip_pkg::PH_SIGNED;
        end else if (zero_ok) begin
          cons_nxt = cons_inc;
          ph_nxt   = aip_pkg::PH_ZERO;
        end else begin
          take     = 1'b1;
          tb       = auto_base;
          base_nxt = auto_base;
        end
      end
      aip_pkg::PH_ZERO: begin
        if (head.is_x) begin
          base_nxt = aip_pkg::BASE_HEX;
          cons_nxt = cons_inc;
          ph_nxt   = aip_pkg::PH_DIGITS;
        end else begin
          take     = 1'b1;
          tb       = zero_base;
          base_nxt = zero_base;
        end
      end
      aip_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      aip_pkg::PH_DONE: begin
        ph_nxt = aip_pkg::PH_DONE;
      end
      default: begin
        ph_nxt = aip_pkg::PH_DONE;
      end
    endcase
    if (take) begin
      if (head.digit < tb) begin
        acc_nxt  = acc * aip_pkg::VALUE_W'(tb) + aip_pkg::VALUE_W'(head.digit);
        cons_nxt = cons_inc;
        ph_nxt   = aip_pkg::PH_DIGITS;
      end else begin
        emit   = 1'b1;
        ph_nxt = aip_pkg::PH_DONE;
      end
    end
  end

  assign out_free = !out_vld_r || out_chan.ready;
  assign pop      = head_vld && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= aip_pkg::PH_DONE;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      base_r <= '0;
      cons_r <= '0;
    end else if (pop) begin
      ph_r   <= ph_nxt;
      neg_r  <= neg_nxt;
      acc_r  <= acc_nxt;
      base_r <= base_nxt;
      cons_r <= cons_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pop && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      value_r <= neg ? ('0 - acc) : acc;
      off_r   <= cons;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.value      = $signed(value_r);
  assign out_chan.end_offset = off_r;

endmodule

FILE: hdl/ascii_integer_parser_core.sv
// Streaming signed-integer parser, one character per request.
// in_chan:  ch and first; first marks the opening character of a string.
// out_chan: value (signed 32 bit, wrapped) and end_offset (16 bit, saturated),
//           at most one result per string, sent on the character that stops the parse.
// cfg_chan: radix, 0 for auto (0x prefix gives hex, else decimal); always ready,
//           write only while no string is in flight.
// Throughput: one character per cycle sustained while out_chan takes results.
// Each digit character costs one multiply-add of the accumulator by the active
// base in the back end. A stopping character passes the front classify register,
// a queue entry and the back end output register before out_chan.valid rises.
// Stall: out_chan holds its result until taken; the back end keeps consuming
// characters that produce no result. A second stopping character waits at the
// queue head, and once one more request fills the queue and one the front
// register, in_chan.ready drops.
// Reset: parse state returns to done (characters without first are dropped),
// radix returns to 10, queue and output are emptied.
module ascii_integer_parser_core (
  input  logic      clk,
  input  logic      rst_n,
  aip_in_if.sink    in_chan,
  aip_out_if.source out_chan,
  aip_cfg_if.sink   cfg_chan
);

  logic                        cls_vld;
  logic                        cls_rdy;
  aip_pkg::cls_t               cls;
  logic                        head_vld;
  aip_pkg::cls_t               head;
  logic                        pop;
  logic [aip_pkg::RADIX_W-1:0] radix_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= aip_pkg::RADIX_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      radix_r <= cfg_chan.radix;
    end
  end

  aip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cls_vld (cls_vld),
    .cls_rdy (cls_rdy),
    .cls     (cls)
  );

  aip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (cls_vld),
    .push_rdy  (cls_rdy),
    .push_data (cls),
    .pop_vld   (head_vld),
    .pop       (pop),
    .pop_data  (head)
  );

  aip_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop),
    .radix    (radix_r),
    .out_chan (out_chan)
  );

endmodule

FILE: hdl/aip_checker.sv
module aip_checker (
  input logic       clk,
  input logic       rst_n,
  aip_in_if.sink    in_chan,
  aip_out_if.source out_chan,
  aip_cfg_if.sink   cfg_chan
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=>
      out_chan.valid && $stable(out_chan.value) && $stable(out_chan.end_offset))
    else $error("stalled result changed or dropped");

  // no result before a request can pass front, queue and back end
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid ##1 !out_chan.valid ##1 !out_chan.valid)
    else $error("result too soon after reset");

  // nothing consumed means no digits
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.end_offset == '0) |-> (out_chan.value == '0))
    else $error("nonzero value with zero end offset");

  // radix writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_chan.valid |-> cfg_chan.ready)
    else $error("radix write stalled");

  // input ready is always driven out of reset
  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_chan.ready))
    else $error("input ready unknown");

endmodule

bind ascii_integer_parser_core aip_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan),
  .cfg_chan (cfg_chan)
);

FILE: verif/aip_checker.sv
module aip_scoreboard (
  input  logic clk,
  input  logic rst_n,
  aip_in_if    in_mon,
  aip_out_if   out_mon,
  aip_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   chars_seen,
  output int   results_seen
);
  import aip_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OFF_W-1:0]          end_offset;
  } parse_result_t;

  parse_result_t      expected_q[$];
  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] base_q;
  phase_t             phase_q;
  logic               neg_q;
  logic [VALUE_W-1:0] acc_q;
  logic [OFF_W-1:0]   count_q;

  int fails = 0;
  int pending_n = 0;
  int chars_n = 0;
  int results_n = 0;

  assign fail_count   = fails;
  assign pending      = pending_n;
  assign chars_seen   = chars_n;
  assign results_seen = results_n;

  function automatic int unsigned char_weight(input logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
    if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
    return 99;
  endfunction

  function void count_char();
    if (count_q < OFF_CAP) count_q = count_q + 1'b1;
  endfunction

  function void digit_or_stop(input logic [CH_W-1:0] c);
    int unsigned  d;
    parse_result_t r;
    d = char_weight(c);
    if (d < base_q) begin
      acc_q = acc_q * base_q + VALUE_W'(d);
      count_char();
      phase_q = PH_DIGITS;
    end else begin
      r.value      = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;
      r.end_offset = count_q;
      expected_q.push_back(r);
      phase_q = PH_DONE;
    end
  endfunction

  function void after_sign(input logic [CH_W-1:0] c);
    if ((radix_q == RADIX_AUTO || radix_q == BASE_HEX) && c == CH_ZERO) begin
      count_char();
      phase_q = PH_ZERO;
    end else begin
      base_q = (radix_q == RADIX_AUTO) ? BASE_DEC : radix_q;
      digit_or_stop(c);
    end
  endfunction

  function void parse_char(input logic [CH_W-1:0] c, input logic first);
    if (first) begin
      phase_q = PH_SPACE;
      neg_q   = 1'b0;
      acc_q   = '0;
      base_q  = '0;
      count_q = '0;
    end
    case (phase_q)
      PH_SPACE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
          count_char();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg_q = (c == CH_MINUS);
          count_char();
          phase_q = PH_SIGNED;
        end else begin
          after_sign(c);
        end
      end
      PH_SIGNED: after_sign(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          base_q = BASE_HEX;
          count_char();
          phase_q = PH_DIGITS;
        end else begin
          base_q = (radix_q == RADIX_AUTO) ? BASE_DEC : BASE_HEX;
          phase_q = PH_DIGITS;
          digit_or_stop(c);
        end
      end
      PH_DIGITS: digit_or_stop(c);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      radix_q = RADIX_RST;
      phase_q = PH_DONE;
      neg_q   = 1'b0;
      acc_q   = '0;
      base_q  = '0;
      count_q = '0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_n++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request pending", out_mon.value, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.value !== want.value)
            report_mismatch("value", out_mon.value, want.value);
          if (out_mon.end_offset !== want.end_offset)
            report_mismatch("end_offset", out_mon.end_offset, want.end_offset);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) radix_q = cfg_mon.radix;
      if (in_mon.valid && in_mon.ready) begin
        chars_n++;
        parse_char(in_mon.ch, in_mon.first);
      end
    end
    pending_n = expected_q.size();
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import aip_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_CHARS  = 155;
  localparam int NUM_PHASES   = 10;

  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_FF    = 8'hFF;

  localparam logic [RADIX_W-1:0] RADIX_PLAN [NUM_PHASES] =
    '{6'd10, 6'd0, 6'd16, 6'd1, 6'd36, 6'd63, 6'd2, 6'd0, 6'd37, 6'd10};

  typedef logic [CH_W-1:0] char_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   quiet = 0;
  int   radix_writes = 0;
  bit   hold_request = 1'b0;
  bit   hold_served = 1'b0;
  int   fails;
  int   pending;
  int   chars_seen;
  int   results_seen;

  aip_in_if  in_chan();
  aip_out_if out_chan();
  aip_cfg_if cfg_chan();

  ascii_integer_parser_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  aip_scoreboard u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_mon      (cfg_chan),
    .fail_count   (fails),
    .pending      (pending),
    .chars_seen   (chars_seen),
    .results_seen (results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end
      out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_char(input logic [CH_W-1:0] c, input logic f);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    in_chan.first <= f;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_text(input char_q_t text);
    foreach (text[i]) send_char(text[i], i == 0);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    settle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.radix <= r;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    radix_writes++;
  endtask

  function automatic char_q_t to_chars(input string s);
    char_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [CH_W-1:0] digit_char(input int v);
    if (v < 10) return CH_W'(CH_ZERO + v);
    return CH_W'(($urandom_range(1) ? CH_LA : CH_UA) + v - 10);
  endfunction

  function automatic char_q_t number_text(input logic [RADIX_W-1:0] r);
    char_q_t t;
    int      b;
    int      n;
    repeat ($urandom_range(3)) begin
      case ($urandom_range(2))
        0: t.push_back(CH_SPACE);
        1: t.push_back(CH_TAB);
        default: t.push_back(CH_LF);
      endcase
    end
    case ($urandom_range(3))
      0: t.push_back(CH_MINUS);
      1: t.push_back(CH_PLUS);
      default: ;
    endcase
    b = (r == RADIX_AUTO) ? 10 : int'(r);
    if ((r == RADIX_AUTO || r == BASE_HEX) && $urandom_range(2) == 0) begin
      t.push_back(CH_ZERO);
      t.push_back($urandom_range(1) ? CH_LX : CH_UX);
      b = 16;
    end
    if (b > 36) b = 36;
    n = ($urandom_range(3) == 0) ? $urandom_range(14) : $urandom_range(1, 9);
    repeat (n) t.push_back(digit_char($urandom_range(b - 1)));
    if ($urandom_range(3) != 0) t.push_back(CH_W'($urandom_range(255)));
    return t;
  endfunction

  function automatic char_q_t noise_text();
    char_q_t t;
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(1)) begin
        t.push_back(CH_W'($urandom_range(255)));
      end else begin
        case ($urandom_range(5))
          0: t.push_back(CH_SPACE);
          1: t.push_back(CH_MINUS);
          2: t.push_back(CH_PLUS);
          3: t.push_back(CH_ZERO);
          4: t.push_back(CH_LX);
          default: t.push_back(CH_UX);
        endcase
      end
    end
    return t;
  endfunction

  initial begin
    char_q_t text;
    int      made;
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    in_chan.first  = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.radix = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_radix(RADIX_PLAN[p]);
      if (p < 4) begin
        in_idle_pct  = 34;
        out_idle_pct = 75;
      end else if (p < 7) begin
        in_idle_pct  = 75;
        out_idle_pct = 34;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      case (p)
        0: begin
          send_char(CH_UA, 1'b0);
          send_text(to_chars(" -!"));
          text = to_chars("+99");
          text.push_back(CH_NUL);
          send_text(text);
          send_char(CH_FF, 1'b1);
        end
        1: begin
          send_text(to_chars("0x!"));
          send_text(to_chars("\t-0XfF;"));
          send_text(to_chars("07,"));
        end
        3: send_text(to_chars("01"));
        7: hold_request = 1'b1;
        default: ;
      endcase

      made = 0;
      while (made < PHASE_CHARS) begin
        if ($urandom_range(4) == 0) text = noise_text();
        else text = number_text(RADIX_PLAN[p]);
        send_text(text);
        made += text.size();
        if ($urandom_range(5) == 0)
          repeat ($urandom_range(1, 2)) send_char(CH_W'($urandom_range(255)), 1'b0);
      end
      // close any open string so the radix may change
      send_char($urandom_range(1) ? CH_COMMA : CH_DOT, 1'b1);
    end

    settle();
    $display("run: %0d characters accepted, %0d results checked, %0d radix writes",
             chars_seen, results_seen, radix_writes);
    $display("run: bases 0 to 63, hex prefixes, signs, wraparound, stray input, stalls");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
